// ===== rtl/f32rem_pkg.sv =====
package f32rem_pkg;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] ABS_MASK   = 32'h7fff_ffff;
    localparam logic [31:0] EXP_MASK   = 32'h7f80_0000;
    localparam logic [31:0] QNAN_BITS  = 32'h7fc0_0000;
    localparam int          SIG_W      = 24;
    localparam int          EXP_W      = 10;
    localparam int          STEPS      = 4;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W     = 1;

    typedef enum logic [1:0]
    {
        CLS_NAN,
        CLS_PASS,
        CLS_ZERO,
        CLS_DIVIDE
    } cls_t;

    // classified item handed from front to back
    typedef struct packed
    {
        cls_t                    cls;
        logic [31:0]             x_bits;
        logic [SIG_W-1:0]        mx;
        logic [SIG_W-1:0]        my;
        logic signed [EXP_W-1:0] ey;
        logic [EXP_W-1:0]        diff;
    } job_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOP,
        ST_NORM,
        ST_DONE
    } back_state_t;

    // leading zero count of a 24-bit significand
    function automatic logic [4:0] lzc24(input logic [SIG_W-1:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < SIG_W; i++)
        begin
            if (v[i])
            begin
                n = 5'(SIG_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/f32rem_if.sv =====
interface f32rem_in_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [31:0] dividend_bits;
    logic [31:0] divisor_bits;
    modport source (output valid, dividend_bits, divisor_bits, input ready);
    modport sink (input valid, dividend_bits, divisor_bits, output ready);
endinterface

interface f32rem_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [31:0] remainder_bits;
    logic        invalid_flag;
    modport source (output valid, remainder_bits, invalid_flag, input ready);
    modport sink (input valid, remainder_bits, invalid_flag, output ready);
endinterface

// ===== rtl/f32rem_front.sv =====
module f32rem_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    f32rem_in_if.sink            in_ch,
    output logic                 job_valid,
    input  logic                 job_ready,
    output f32rem_pkg::job_t     job
);
    import f32rem_pkg::*;

    logic        valid_reg;
    job_t        job_reg;
    job_t        job_next;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [4:0]  lx;
    logic [4:0]  ly;
    logic signed [EXP_W-1:0] ex;
    logic signed [EXP_W-1:0] ey;
    logic signed [EXP_W-1:0] d;

    assign in_ch.ready = !valid_reg || job_ready;
    assign job_valid   = valid_reg;
    assign job         = job_reg;

    always_comb
    begin
        ax = in_ch.dividend_bits & ABS_MASK;
        ay = in_ch.divisor_bits & ABS_MASK;
        lx = lzc24(ax[23:0]);
        ly = lzc24(ay[23:0]);
        job_next        = '0;
        job_next.x_bits = in_ch.dividend_bits;
        if (ax[30:23] == 8'd0)
        begin
            job_next.mx = 24'(ax[23:0] << lx);
            ex          = EXP_W'(1) - EXP_W'(lx);
        end
        else
        begin
            job_next.mx = {1'b1, ax[22:0]};
            ex          = EXP_W'(ax[30:23]);
        end
        if (ay[30:23] == 8'd0)
        begin
            job_next.my = 24'(ay[23:0] << ly);
            ey          = EXP_W'(1) - EXP_W'(ly);
        end
        else
        begin
            job_next.my = {1'b1, ay[22:0]};
            ey          = EXP_W'(ay[30:23]);
        end
        d             = ex - ey;
        job_next.ey   = ey;
        job_next.diff = d;
        priority if (ax >= EXP_MASK || ay > EXP_MASK || ay == 32'd0)
        begin
            job_next.cls = CLS_NAN;
        end
        else if (ax < ay)
        begin
            job_next.cls = CLS_PASS;
        end
        else if (ax == ay)
        begin
            job_next.cls = CLS_ZERO;
        end
        else
        begin
            job_next.cls = CLS_DIVIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            job_reg <= job_next;
        end
    end
endmodule

// ===== rtl/f32rem_queue.sv =====
module f32rem_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  f32rem_pkg::job_t     wr_job,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output f32rem_pkg::job_t     rd_job
);
    import f32rem_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_job   = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end
endmodule

// ===== rtl/f32rem_back.sv =====
module f32rem_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  f32rem_pkg::job_t     job,
    f32rem_out_if.source         out_ch
);
    import f32rem_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic [SIG_W:0]          mx_reg;
    logic [SIG_W:0]          mx_next;
    logic [SIG_W-1:0]        my_reg;
    logic signed [EXP_W-1:0] ey_reg;
    logic [EXP_W-1:0]        cnt_reg;
    logic [EXP_W-1:0]        cnt_next;
    logic                    sign_reg;
    logic [31:0]             res_reg;
    logic [31:0]             res_next;
    logic                    inv_reg;
    logic                    load;
    logic                    finish;
    logic [SIG_W:0]          m;
    logic [SIG_W-1:0]        r;
    logic [4:0]              lz;
    logic signed [EXP_W-1:0] en;
    logic [EXP_W-1:0]        sh;

    assign job_ready             = state_reg == ST_IDLE;
    assign load                  = job_valid && job_ready;
    assign out_ch.valid          = state_reg == ST_DONE;
    assign out_ch.remainder_bits = res_reg;
    assign out_ch.invalid_flag   = inv_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job.cls == CLS_DIVIDE) ? ST_LOOP : ST_DONE;
                end
            end
            ST_LOOP:
            begin
                if (cnt_reg <= EXP_W'(STEPS))
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // up to four restoring steps per cycle
    always_comb
    begin
        m        = mx_reg;
        cnt_next = cnt_reg;
        for (int i = 0; i < STEPS; i++)
        begin
            if (cnt_next != '0)
            begin
                if (m >= {1'b0, my_reg})
                begin
                    m = (m - {1'b0, my_reg}) << 1;
                end
                else
                begin
                    m = m << 1;
                end
                cnt_next = cnt_next - 1'b1;
            end
        end
        mx_next = m;
    end

    // final subtract, renormalize and pack
    always_comb
    begin
        r = (mx_reg >= {1'b0, my_reg}) ? 24'(mx_reg - {1'b0, my_reg}) : mx_reg[SIG_W-1:0];
        lz = lzc24(r);
        en = ey_reg - EXP_W'(lz);
        sh = EXP_W'(1) - en;
        if (r == '0)
        begin
            res_next = {sign_reg, 31'd0};
        end
        else if (en > 0)
        begin
            res_next = {sign_reg, en[7:0], 23'(r << lz)};
        end
        else if (sh > EXP_W'(31))
        begin
            res_next = {sign_reg, 31'd0};
        end
        else
        begin
            res_next = {sign_reg, 31'((32'(r << lz)) >> sh[4:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign finish = state_reg == ST_NORM;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mx_reg   <= {1'b0, job.mx};
            my_reg   <= job.my;
            ey_reg   <= job.ey;
            cnt_reg  <= job.diff;
            sign_reg <= job.x_bits[31];
            inv_reg  <= job.cls == CLS_NAN;
            unique case (job.cls)
                CLS_NAN:    res_reg <= QNAN_BITS;
                CLS_PASS:   res_reg <= job.x_bits;
                CLS_ZERO:   res_reg <= job.x_bits & SIGN_MASK;
                CLS_DIVIDE: res_reg <= '0;
                default:    res_reg <= '0;
            endcase
        end
        else if (state_reg == ST_LOOP)
        begin
            mx_reg  <= mx_next;
            cnt_reg <= cnt_next;
        end
        else if (finish)
        begin
            res_reg <= res_next;
        end
    end
endmodule

// ===== rtl/float32_remainder_fmod.sv =====
// channel | dir | beat
// in_ch   | in  | dividend_bits, divisor_bits
// out_ch  | out | remainder_bits, invalid_flag
// front classifies and normalizes into a registered job, then a two-entry queue
// back runs 4 shift-subtract steps a cycle, diff steps per item,
// diff being the exponent difference (at most 276)
// special cases skip the loop and normalize states in the back
// rst_n clears handshake and state, payload registers are not reset
// each side stalls on its own while the queue has room
module float32_remainder_fmod
(
    input logic          clk,
    input logic          rst_n,
    f32rem_in_if.sink    in_ch,
    f32rem_out_if.source out_ch
);
    import f32rem_pkg::*;

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    f32rem_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    f32rem_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    f32rem_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_ch    (out_ch)
    );
endmodule
